/* rtl/core/prdm_pkg.sv */
// Shared types, constants and the axis mapping table of the pen report decoder.
package prdm_pkg;

    localparam int RAW_W   = 16;
    localparam int RES_W   = 11;
    localparam int PROD_W  = RAW_W + RES_W;
    localparam int DVD_W   = 28;
    localparam int REM_W   = RAW_W;
    localparam int DIV_STEPS = DVD_W / 2;
    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;

    localparam logic [2:0] FAIL_LIMIT = 3'd5;

    localparam logic [7:0] HDR_SHORT = 8'h02;
    localparam logic [7:0] HDR_LONG  = 8'h1a;

    localparam int BIT_TIP    = 0;
    localparam int BIT_SIDE1  = 1;
    localparam int BIT_ERASER = 2;
    localparam int BIT_INVERT = 3;
    localparam int BIT_SIDE2  = 4;
    localparam int BIT_PROX   = 5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_READ_FAIL = 2'd1;
    localparam logic [1:0] ST_BAD_HDR   = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic [IDX_W-1:0] REG_X_MAX    = 3'd0;
    localparam logic [IDX_W-1:0] REG_Y_MAX    = 3'd1;
    localparam logic [IDX_W-1:0] REG_P_MAX    = 3'd2;
    localparam logic [IDX_W-1:0] REG_X_RES    = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_RES    = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAP_MODE = 3'd5;
    localparam logic [IDX_W-1:0] REG_COMPACT  = 3'd6;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] v;
        logic [RES_W-1:0] res;
        logic [RAW_W-1:0] maxv;
    } scl_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] q;
    } scl_rsp_t;

    typedef struct packed {
        logic src_y;
        logic inv;
        logic res_x;
        logic post_sub;
    } map_sel_t;

    typedef struct packed {
        map_sel_t sx;
        map_sel_t sy;
    } map_pair_t;

    function automatic map_pair_t map_sel(input logic [2:0] mode);
        map_pair_t p;
        unique case (mode)
            3'd0:    p = '{sx: '{1'b1, 1'b0, 1'b1, 1'b1}, sy: '{1'b0, 1'b0, 1'b0, 1'b1}};
            3'd1:    p = '{sx: '{1'b1, 1'b0, 1'b1, 1'b0}, sy: '{1'b0, 1'b1, 1'b0, 1'b0}};
            3'd2:    p = '{sx: '{1'b1, 1'b0, 1'b1, 1'b0}, sy: '{1'b0, 1'b0, 1'b0, 1'b0}};
            3'd3:    p = '{sx: '{1'b0, 1'b0, 1'b1, 1'b0}, sy: '{1'b1, 1'b1, 1'b0, 1'b0}};
            3'd4:    p = '{sx: '{1'b0, 1'b0, 1'b1, 1'b0}, sy: '{1'b1, 1'b0, 1'b0, 1'b0}};
            3'd5:    p = '{sx: '{1'b1, 1'b1, 1'b0, 1'b0}, sy: '{1'b0, 1'b0, 1'b1, 1'b0}};
            3'd6:    p = '{sx: '{1'b1, 1'b0, 1'b0, 1'b0}, sy: '{1'b0, 1'b0, 1'b1, 1'b0}};
            default: p = '{sx: '{1'b0, 1'b1, 1'b1, 1'b0}, sy: '{1'b1, 1'b0, 1'b0, 1'b0}};
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/pen_report_decode_and_map_top.sv */
// Top level of the pen report decoder: checks, state, sequencer and output register.
//
// One pen report enters per word on the s_ channel; exactly one result word
// leaves on the m_ channel for each report, in order. The result carries an
// emit flag and a status code in m_tuser; a word with emit low is still
// delivered and must be taken.
// A good report goes through a check step, then two scaled coordinates, each
// through the shared scaling unit (a multiply, then the two-bit divide steps,
// then a hand-off), then a step that forms the result. A failed report goes
// from the check straight to forming the result. s_tready is high only while
// no report is in progress, so a new report is taken only after the last one
// has left its final step; the iterative divider sets the sustained rate.
// The result sits in an output register; a new report can be taken while it
// waits, and a stalled m_ side holds the next result in its last step until
// the register frees up. The user must write configuration through cfg_wr_en,
// cfg_index and cfg_wdata only while the block is idle; the block itself does
// not enforce this. Reset restores the default registers, clears proximity,
// tool, tip and failure state, and empties the output register.
module pen_report_decode_and_map_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pen_status, raw_y, raw_x, raw_pressure
    input  logic [55:0] s_tdata,
    // read_ok, header
    input  logic [8:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // touch, in_prox, eraser_tool, side_button_one, side_button_two, screen_x,
    // screen_y, pressure, device_ready, reset_request, zero fill
    output logic [47:0] m_tdata,
    // emit, status
    output logic [2:0]  m_tuser
);
    import prdm_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_SX_WAIT = 3'd2;
    localparam logic [2:0] S_SY_WAIT = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;

    logic [2:0]       state_reg;
    logic [RAW_W-1:0] x_max_reg;
    logic [RAW_W-1:0] y_max_reg;
    logic [RAW_W-1:0] p_max_reg;
    logic [RES_W-1:0] x_res_reg;
    logic [RES_W-1:0] y_res_reg;
    logic [2:0]       map_mode_reg;
    logic             compact_reg;

    logic             rok_reg;
    logic [7:0]       hdr_reg;
    logic [7:0]       pst_reg;
    logic [RAW_W-1:0] ry_reg;
    logic [RAW_W-1:0] rx_reg;
    logic [RAW_W-1:0] rp_reg;
    logic [1:0]       code_reg;
    logic [RES_W-1:0] sx_reg;
    logic [RES_W-1:0] sy_reg;

    logic             prox_seen_reg;
    logic             eraser_reg;
    logic             tip_was_down_reg;
    logic [2:0]       fail_count_reg;

    logic             m_tvalid_reg;
    logic [47:0]      m_tdata_reg;
    logic [2:0]       m_tuser_reg;

    scl_req_t         req;
    scl_rsp_t         rsp;
    map_pair_t        pair;
    map_sel_t         cur;
    logic [1:0]       code_calc;
    logic [RES_W-1:0] post_q;
    logic             out_free;
    logic             eraser_next;
    logic             emit_next;
    logic             twd_next;
    logic             touch_calc;
    logic             prox_calc;

    prdm_scale u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        priority if (!rok_reg)
            code_calc = ST_READ_FAIL;
        else if (hdr_reg != HDR_SHORT && hdr_reg != HDR_LONG)
            code_calc = ST_BAD_HDR;
        else if (rx_reg > x_max_reg || ry_reg > y_max_reg || rp_reg > p_max_reg)
            code_calc = ST_RANGE;
        else
            code_calc = ST_OK;
    end

    always_comb
    begin
        pair = map_sel(map_mode_reg);
        cur  = (state_reg == S_CHECK) ? pair.sx : pair.sy;

        req.start = ((state_reg == S_CHECK) && (code_calc == ST_OK))
                  || ((state_reg == S_SX_WAIT) && rsp.done);
        if (cur.src_y)
        begin
            req.v    = cur.inv ? RAW_W'(y_max_reg - ry_reg) : ry_reg;
            req.maxv = y_max_reg;
        end
        else
        begin
            req.v    = cur.inv ? RAW_W'(x_max_reg - rx_reg) : rx_reg;
            req.maxv = x_max_reg;
        end
        req.res = cur.res_x ? x_res_reg : y_res_reg;
    end

    always_comb
    begin
        map_sel_t ps;
        logic [RES_W-1:0] pres;
        ps   = (state_reg == S_SX_WAIT) ? pair.sx : pair.sy;
        pres = ps.res_x ? x_res_reg : y_res_reg;
        post_q = ps.post_sub ? RES_W'(pres - rsp.q) : rsp.q;
    end

    always_comb
    begin
        touch_calc  = pst_reg[BIT_TIP] | pst_reg[BIT_ERASER];
        prox_calc   = pst_reg[BIT_PROX];
        eraser_next = prox_seen_reg ? eraser_reg
                                    : (pst_reg[BIT_ERASER] | pst_reg[BIT_INVERT]);
        twd_next    = tip_was_down_reg;
        emit_next   = 1'b1;
        if (compact_reg)
        begin
            priority if (pst_reg[BIT_TIP])
            begin
                twd_next  = 1'b1;
                emit_next = 1'b1;
            end
            else if (tip_was_down_reg)
            begin
                twd_next  = 1'b0;
                emit_next = 1'b1;
            end
            else
            begin
                emit_next = 1'b0;
            end
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            x_max_reg        <= 16'hffff;
            y_max_reg        <= 16'hffff;
            p_max_reg        <= 16'hffff;
            x_res_reg        <= 11'd800;
            y_res_reg        <= 11'd600;
            map_mode_reg     <= 3'd3;
            compact_reg      <= 1'b0;
            rok_reg          <= 1'b0;
            hdr_reg          <= '0;
            pst_reg          <= '0;
            ry_reg           <= '0;
            rx_reg           <= '0;
            rp_reg           <= '0;
            code_reg         <= ST_OK;
            sx_reg           <= '0;
            sy_reg           <= '0;
            prox_seen_reg    <= 1'b0;
            eraser_reg       <= 1'b0;
            tip_was_down_reg <= 1'b0;
            fail_count_reg   <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tuser_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_X_MAX:    x_max_reg    <= cfg_wdata;
                    REG_Y_MAX:    y_max_reg    <= cfg_wdata;
                    REG_P_MAX:    p_max_reg    <= cfg_wdata;
                    REG_X_RES:    x_res_reg    <= cfg_wdata[RES_W-1:0];
                    REG_Y_RES:    y_res_reg    <= cfg_wdata[RES_W-1:0];
                    REG_MAP_MODE: map_mode_reg <= cfg_wdata[2:0];
                    REG_COMPACT:  compact_reg  <= cfg_wdata[0];
                    default:      ;
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != S_FINISH))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        pst_reg   <= s_tdata[7:0];
                        ry_reg    <= s_tdata[23:8];
                        rx_reg    <= s_tdata[39:24];
                        rp_reg    <= s_tdata[55:40];
                        rok_reg   <= s_tuser[0];
                        hdr_reg   <= s_tuser[8:1];
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    code_reg  <= code_calc;
                    state_reg <= (code_calc == ST_OK) ? S_SX_WAIT : S_FINISH;
                end
                S_SX_WAIT:
                begin
                    if (rsp.done)
                    begin
                        sx_reg    <= post_q;
                        state_reg <= S_SY_WAIT;
                    end
                end
                S_SY_WAIT:
                begin
                    if (rsp.done)
                    begin
                        sy_reg    <= post_q;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                        if (code_reg != ST_OK)
                        begin
                            // Failed reports leave pen state alone.
                            m_tuser_reg <= {code_reg, 1'b0};
                            if (fail_count_reg > FAIL_LIMIT)
                            begin
                                fail_count_reg <= '0;
                                m_tdata_reg    <= {3'b0, 1'b1, 44'b0};
                            end
                            else
                            begin
                                fail_count_reg <= fail_count_reg + 1'b1;
                                m_tdata_reg    <= '0;
                            end
                        end
                        else
                        begin
                            fail_count_reg   <= '0;
                            eraser_reg       <= eraser_next;
                            prox_seen_reg    <= prox_calc;
                            tip_was_down_reg <= twd_next;
                            m_tuser_reg      <= {ST_OK, emit_next};
                            m_tdata_reg      <= {3'b0, 1'b0, prox_calc, rp_reg,
                                                 sy_reg, sx_reg,
                                                 pst_reg[BIT_SIDE2], pst_reg[BIT_SIDE1],
                                                 eraser_next, prox_calc, touch_calc};
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("report accepted while another is in progress");

    a_reset_req_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[44]) |-> (m_tuser[2:1] != ST_OK && !m_tuser[0]))
        else $error("reset request on a good or emitted report");

    a_fail_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fail_count_reg <= FAIL_LIMIT + 3'd1)
        else $error("failure count passed its limit");

    a_scale_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == S_SX_WAIT || state_reg == S_SY_WAIT))
        else $error("scaling result arrived with no request open");

endmodule

/* rtl/core/prdm_scale.sv */
// Shared scaling unit: one multiply, then a two-bit-per-cycle restoring divide.
module prdm_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  prdm_pkg::scl_req_t req,
    output prdm_pkg::scl_rsp_t rsp
);
    import prdm_pkg::*;

    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_MUL  = 2'd1;
    localparam logic [1:0] SC_DIV  = 2'd2;

    logic [1:0]       state_reg;
    logic [RAW_W-1:0] v_reg;
    logic [RES_W-1:0] res_reg;
    logic [RAW_W-1:0] max_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [REM_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [RES_W-1:0] q_reg;

    logic [REM_W:0]   t0;
    logic [REM_W:0]   t1;
    logic             ge0;
    logic             ge1;
    logic [REM_W-1:0] r0;
    logic [REM_W-1:0] rem_next;
    logic [DVD_W-1:0] dvd_next;

    always_comb
    begin
        t0  = {rem_reg, dvd_reg[DVD_W-1]};
        ge0 = (t0 >= {1'b0, max_reg});
        r0  = ge0 ? REM_W'(t0 - {1'b0, max_reg}) : t0[REM_W-1:0];
        t1  = {r0, dvd_reg[DVD_W-2]};
        ge1 = (t1 >= {1'b0, max_reg});
        rem_next = ge1 ? REM_W'(t1 - {1'b0, max_reg}) : t1[REM_W-1:0];
        dvd_next = {dvd_reg[DVD_W-3:0], ge0, ge1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            v_reg     <= '0;
            res_reg   <= '0;
            max_reg   <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            q_reg     <= '0;
        end
        else
        begin
            done_reg <= (state_reg == SC_DIV) && (cnt_reg == CNT_W'(DIV_STEPS - 1));
            case (state_reg)
                SC_IDLE:
                begin
                    if (req.start)
                    begin
                        v_reg     <= req.v;
                        res_reg   <= req.res;
                        max_reg   <= req.maxv;
                        state_reg <= SC_MUL;
                    end
                end
                SC_MUL:
                begin
                    dvd_reg   <= DVD_W'(PROD_W'(v_reg) * PROD_W'(res_reg));
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= SC_DIV;
                end
                SC_DIV:
                begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        // A zero divisor gives a zero quotient.
                        q_reg     <= (max_reg == '0) ? '0 : dvd_next[RES_W-1:0];
                        state_reg <= SC_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

endmodule

/* bench/pen_report_decode_and_map_top_tb.sv */
// Self-checking bench for the pen report decoder: directed and random reports checked against a local predictor.
`timescale 1ns / 100ps

module pen_report_decode_and_map_top_tb;
    import prdm_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 400;
    localparam int LONG_STALL_AT  = 150;
    localparam int PRINT_LIMIT    = 30;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REPORTS  = 34;

    typedef enum logic [2:0] {
        MAP_YX_POSTSUB    = 3'd0,
        MAP_YX_INV_Y      = 3'd1,
        MAP_YX            = 3'd2,
        MAP_XY_INV_Y      = 3'd3,
        MAP_XY            = 3'd4,
        MAP_YX_INV_SWRES  = 3'd5,
        MAP_YX_SWRES      = 3'd6,
        MAP_XY_INV_X      = 3'd7
    } map_mode_e;

    typedef struct packed {
        logic [15:0] x_max;
        logic [15:0] y_max;
        logic [15:0] p_max;
        logic [10:0] x_res;
        logic [10:0] y_res;
        map_mode_e   map_mode;
        logic        compact;
    } reg_set_t;

    typedef struct packed {
        logic        read_ok;
        logic [7:0]  header;
        logic [7:0]  pen_status;
        logic [15:0] raw_y;
        logic [15:0] raw_x;
        logic [15:0] raw_pressure;
    } pen_report_t;

    typedef struct packed {
        logic        emit;
        logic [1:0]  status;
        logic        touch;
        logic        in_prox;
        logic        eraser_tool;
        logic        side_one;
        logic        side_two;
        logic [10:0] screen_x;
        logic [10:0] screen_y;
        logic [15:0] pressure;
        logic        device_ready;
        logic        reset_request;
    } pen_result_t;

    localparam reg_set_t RESET_SETTINGS =
        '{16'hffff, 16'hffff, 16'hffff, 11'd800, 11'd600, MAP_XY_INV_Y, 1'b0};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = REG_X_MAX;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [8:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    pen_report_decode_and_map_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the block's registers and state.
    reg_set_t    cfg_now = RESET_SETTINGS;
    logic        prox_seen = 1'b0;
    logic        eraser_latched = 1'b0;
    logic        tip_was_down = 1'b0;
    logic [2:0]  fails_in_row = '0;

    pen_report_t report_backlog[$];
    pen_result_t pending_results[$];

    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_emitted = 0;
    int n_rejected = 0;
    int n_reset_req = 0;
    int n_settings = 1;
    logic calm = 1'b0;
    logic pen_down = 1'b0;
    logic pen_near = 1'b1;

    function automatic logic [31:0] scaled(input logic [15:0] v, input logic [10:0] res,
                                           input logic [15:0] maxv);
        if (maxv == 16'd0)
            return 32'd0;
        return (32'(v) * 32'(res)) / 32'(maxv);
    endfunction

    function automatic pen_result_t decode_report(input pen_report_t rp);
        pen_result_t r;
        logic [1:0]  code;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [15:0] rx;
        logic [15:0] ry;
        r = '0;
        rx = rp.raw_x;
        ry = rp.raw_y;
        code = ST_OK;
        if (!rp.read_ok)
            code = ST_READ_FAIL;
        else if (rp.header != HDR_SHORT && rp.header != HDR_LONG)
            code = ST_BAD_HDR;
        else if (rx > cfg_now.x_max || ry > cfg_now.y_max || rp.raw_pressure > cfg_now.p_max)
            code = ST_RANGE;

        if (code != ST_OK)
        begin
            r.status = code;
            n_rejected++;
            if (fails_in_row > FAIL_LIMIT)
            begin
                fails_in_row = '0;
                r.reset_request = 1'b1;
                n_reset_req++;
            end
            else
                fails_in_row = fails_in_row + 3'd1;
            return r;
        end
        fails_in_row = '0;

        case (cfg_now.map_mode)
            MAP_YX_POSTSUB:
            begin
                sx = 32'(cfg_now.x_res) - scaled(ry, cfg_now.x_res, cfg_now.y_max);
                sy = 32'(cfg_now.y_res) - scaled(rx, cfg_now.y_res, cfg_now.x_max);
            end
            MAP_YX_INV_Y:
            begin
                sx = scaled(ry, cfg_now.x_res, cfg_now.y_max);
                sy = scaled(cfg_now.x_max - rx, cfg_now.y_res, cfg_now.x_max);
            end
            MAP_YX:
            begin
                sx = scaled(ry, cfg_now.x_res, cfg_now.y_max);
                sy = scaled(rx, cfg_now.y_res, cfg_now.x_max);
            end
            MAP_XY_INV_Y:
            begin
                sx = scaled(rx, cfg_now.x_res, cfg_now.x_max);
                sy = scaled(cfg_now.y_max - ry, cfg_now.y_res, cfg_now.y_max);
            end
            MAP_XY:
            begin
                sx = scaled(rx, cfg_now.x_res, cfg_now.x_max);
                sy = scaled(ry, cfg_now.y_res, cfg_now.y_max);
            end
            MAP_YX_INV_SWRES:
            begin
                sx = scaled(cfg_now.y_max - ry, cfg_now.y_res, cfg_now.y_max);
                sy = scaled(rx, cfg_now.x_res, cfg_now.x_max);
            end
            MAP_YX_SWRES:
            begin
                sx = scaled(ry, cfg_now.y_res, cfg_now.y_max);
                sy = scaled(rx, cfg_now.x_res, cfg_now.x_max);
            end
            default:
            begin
                sx = scaled(cfg_now.x_max - rx, cfg_now.x_res, cfg_now.x_max);
                sy = scaled(ry, cfg_now.y_res, cfg_now.y_max);
            end
        endcase

        // The tool is only latched when the last good report had the pen out of range.
        if (!prox_seen)
            eraser_latched = rp.pen_status[BIT_ERASER] | rp.pen_status[BIT_INVERT];
        prox_seen = rp.pen_status[BIT_PROX];

        if (!cfg_now.compact)
            r.emit = 1'b1;
        else if (rp.pen_status[BIT_TIP])
        begin
            tip_was_down = 1'b1;
            r.emit = 1'b1;
        end
        else if (tip_was_down)
        begin
            tip_was_down = 1'b0;
            r.emit = 1'b1;
        end

        if (r.emit)
            n_emitted++;
        r.touch = rp.pen_status[BIT_TIP] | rp.pen_status[BIT_ERASER];
        r.in_prox = rp.pen_status[BIT_PROX];
        r.eraser_tool = eraser_latched;
        r.side_one = rp.pen_status[BIT_SIDE1];
        r.side_two = rp.pen_status[BIT_SIDE2];
        r.screen_x = sx[10:0];
        r.screen_y = sy[10:0];
        r.pressure = rp.raw_pressure;
        r.device_ready = rp.pen_status[BIT_PROX];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < PRINT_LIMIT)
            $display("result %0d: %s is %0d, expected %0d", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Sender side.
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        pen_report_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(decode_report(
                    '{s_tuser[0], s_tuser[8:1], s_tdata[7:0], s_tdata[23:8],
                      s_tdata[39:24], s_tdata[55:40]}));
                n_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (report_backlog.size() > 0)
                begin
                    nxt = report_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {nxt.raw_pressure, nxt.raw_x, nxt.raw_y, nxt.pen_status};
                    s_tuser <= {nxt.header, nxt.read_ok};
                    gap_left = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side.
    int   stall_left = 0;
    logic long_stall_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        pen_result_t got;
        pen_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tuser[0], m_tuser[2:1], m_tdata[0], m_tdata[1], m_tdata[2],
                        m_tdata[3], m_tdata[4], m_tdata[15:5], m_tdata[26:16],
                        m_tdata[42:27], m_tdata[43], m_tdata[44]};
                if (pending_results.size() == 0)
                    report_mismatch("word with nothing expected, status", got.status, 0);
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("emit", got.emit, want.emit);
                    compare_field("status", got.status, want.status);
                    compare_field("touch", got.touch, want.touch);
                    compare_field("in_prox", got.in_prox, want.in_prox);
                    compare_field("eraser_tool", got.eraser_tool, want.eraser_tool);
                    compare_field("side_button_one", got.side_one, want.side_one);
                    compare_field("side_button_two", got.side_two, want.side_two);
                    compare_field("screen_x", got.screen_x, want.screen_x);
                    compare_field("screen_y", got.screen_y, want.screen_y);
                    compare_field("pressure", got.pressure, want.pressure);
                    compare_field("device_ready", got.device_ready, want.device_ready);
                    compare_field("reset_request", got.reset_request, want.reset_request);
                    compare_field("zero fill", m_tdata[47:45], 0);
                end
                n_results++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!long_stall_done && n_results >= LONG_STALL_AT)
            begin
                long_stall_done = 1'b1;
                stall_left = LONG_STALL;
                m_tready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_report(input logic rok, input logic [7:0] hdr, input logic [7:0] st,
                               input logic [15:0] ry, input logic [15:0] rx,
                               input logic [15:0] rp);
        report_backlog.push_back('{rok, hdr, st, ry, rx, rp});
        n_queued++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input reg_set_t c);
        write_reg(REG_X_MAX, c.x_max);
        write_reg(REG_Y_MAX, c.y_max);
        write_reg(REG_P_MAX, c.p_max);
        write_reg(REG_X_RES, 16'(c.x_res));
        write_reg(REG_Y_RES, 16'(c.y_res));
        write_reg(REG_MAP_MODE, 16'(c.map_mode));
        write_reg(REG_COMPACT, 16'(c.compact));
        cfg_wr_en <= 1'b0;
        cfg_now = c;
        n_settings++;
    endtask

    function automatic int pick_limit(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    function automatic logic [15:0] pick_raw(input logic [15:0] maxv);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return maxv;
        return 16'($urandom_range(0, maxv));
    endfunction

    task automatic push_failure();
        logic [7:0]  hdr;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] rp;
        int          kind;
        int          which;
        kind = $urandom_range(0, 2);
        hdr = $urandom_range(0, 1) ? HDR_SHORT : HDR_LONG;
        rx = pick_raw(cfg_now.x_max);
        ry = pick_raw(cfg_now.y_max);
        rp = pick_raw(cfg_now.p_max);
        if (kind == 0)
        begin
            push_report(1'b0, 8'($urandom()), 8'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'($urandom()));
            return;
        end
        if (kind == 2)
        begin
            which = $urandom_range(0, 2);
            if (which == 0 && cfg_now.x_max != 16'hffff)
                rx = 16'($urandom_range(32'(cfg_now.x_max) + 1, 65535));
            else if (which == 1 && cfg_now.y_max != 16'hffff)
                ry = 16'($urandom_range(32'(cfg_now.y_max) + 1, 65535));
            else if (which == 2 && cfg_now.p_max != 16'hffff)
                rp = 16'($urandom_range(32'(cfg_now.p_max) + 1, 65535));
            else
                kind = 1;
        end
        if (kind == 1)
        begin
            hdr = 8'($urandom());
            if (hdr == HDR_SHORT || hdr == HDR_LONG)
                hdr = hdr ^ 8'h80;
        end
        push_report(1'b1, hdr, 8'($urandom()), ry, rx, rp);
    endtask

    // Mostly pen strokes: proximity and tip change now and then, the rest of the status
    // byte is random. Some single failures and some long failure runs mixed in.
    task automatic push_random_report();
        logic [7:0] st;
        int         r;
        int         burst;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            burst = $urandom_range(6, 9);
            repeat (burst) push_failure();
            return;
        end
        if (r < 14)
        begin
            push_failure();
            return;
        end
        if ($urandom_range(0, 7) == 0)
            pen_near = !pen_near;
        if ($urandom_range(0, 4) == 0)
            pen_down = !pen_down;
        st = 8'($urandom());
        st[BIT_PROX] = pen_near;
        st[BIT_TIP] = pen_down && pen_near;
        push_report(1'b1, $urandom_range(0, 1) ? HDR_SHORT : HDR_LONG, st,
                    pick_raw(cfg_now.y_max), pick_raw(cfg_now.x_max), pick_raw(cfg_now.p_max));
    endtask

    initial
    begin
        reg_set_t c;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: header checks, tool latch, failure run up to a reset request.
        push_report(1'b1, HDR_SHORT, 8'h00, 16'h0000, 16'h0000, 16'h0000);
        push_report(1'b1, HDR_LONG, 8'hff, 16'hffff, 16'hffff, 16'hffff);
        push_report(1'b1, HDR_SHORT, 8'h21, 16'd100, 16'd200, 16'd300);
        push_report(1'b1, HDR_SHORT, 8'h01, 16'd5000, 16'd6000, 16'd700);
        push_report(1'b1, HDR_LONG, 8'h21, 16'd40000, 16'd30000, 16'd1);
        push_report(1'b1, HDR_SHORT, 8'h12, 16'h8000, 16'h7fff, 16'h5555);
        push_report(1'b1, HDR_SHORT, 8'h24, 16'haaaa, 16'h5555, 16'haaaa);
        push_report(1'b0, HDR_SHORT, 8'h21, 16'd1, 16'd1, 16'd1);
        push_report(1'b1, 8'h00, 8'h21, 16'd1, 16'd1, 16'd1);
        push_report(1'b1, 8'hff, 8'h21, 16'd1, 16'd1, 16'd1);
        push_report(1'b1, 8'h03, 8'h21, 16'd1, 16'd1, 16'd1);
        push_report(1'b0, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff);
        push_report(1'b0, HDR_LONG, 8'h00, 16'd0, 16'd0, 16'd0);
        push_report(1'b0, HDR_LONG, 8'h00, 16'd0, 16'd0, 16'd0);
        push_report(1'b0, HDR_LONG, 8'h00, 16'd0, 16'd0, 16'd0);
        push_report(1'b1, HDR_SHORT, 8'h20, 16'd10, 16'd10, 16'd10);
        drain();

        // Small maxima in compact mode: range checks and the release report.
        c = '{16'd1000, 16'd2000, 16'd500, 11'd2047, 11'd1, MAP_YX_POSTSUB, 1'b1};
        apply_settings(c);
        push_report(1'b1, HDR_SHORT, 8'h20, 16'd100, 16'd100, 16'd100);
        push_report(1'b1, HDR_SHORT, 8'h21, 16'd2000, 16'd1000, 16'd500);
        push_report(1'b1, HDR_LONG, 8'h23, 16'd0, 16'd0, 16'd0);
        push_report(1'b1, HDR_SHORT, 8'h20, 16'd1500, 16'd700, 16'd250);
        push_report(1'b1, HDR_SHORT, 8'h20, 16'd1500, 16'd700, 16'd250);
        push_report(1'b1, HDR_SHORT, 8'h21, 16'd100, 16'd1001, 16'd0);
        push_report(1'b1, HDR_SHORT, 8'h21, 16'd2001, 16'd100, 16'd0);
        push_report(1'b1, HDR_SHORT, 8'h21, 16'd100, 16'd100, 16'd501);
        push_report(1'b1, HDR_SHORT, 8'h21, 16'd1999, 16'd999, 16'd499);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                c = '{16'hffff, 16'hffff, 16'hffff, 11'd2047, 11'd2047, MAP_YX_POSTSUB, 1'b0};
            else if (p == 1)
                c = '{16'd1, 16'd1, 16'd0, 11'd1, 11'd1, MAP_YX_INV_Y, 1'b1};
            else
            begin
                c.x_max = 16'(pick_limit(1, 65535));
                c.y_max = 16'(pick_limit(1, 65535));
                c.p_max = 16'(pick_limit(0, 65535));
                c.x_res = 11'(pick_limit(1, 2047));
                c.y_res = 11'(pick_limit(1, 2047));
                c.map_mode = (p < 8) ? map_mode_e'(p) : map_mode_e'($urandom_range(0, 7));
                c.compact = p[0];
            end
            apply_settings(c);
            calm = (p == 5);
            for (int k = 0; k < PHASE_REPORTS; k++)
            begin
                push_random_report();
                // Let everything come out in the middle of one phase.
                if (p == 2 && k == PHASE_REPORTS / 2)
                    drain();
            end
            drain();
            calm = 1'b0;
        end

        repeat (40) @(posedge clk);
        $display("%0d reports under %0d register settings, all eight axis mappings", n_accepted,
                 n_settings);
        $display("%0d reports emitted, %0d rejected, %0d reset requests, %0d results checked",
                 n_emitted, n_rejected, n_reset_req, n_results);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/prdm_pkg.sv
rtl/core/prdm_scale.sv
rtl/core/pen_report_decode_and_map_top.sv
bench/pen_report_decode_and_map_top_tb.sv
